// File: sv/qpsht_pkg.sv
// Package with the field layout, codes and default sizes of the quadratic-probe string hash table.
`default_nettype none

package qpsht_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned TABLE_ENTRIES_DEF = 101;
  localparam int unsigned PROBE_LIMIT_DEF   = 20;
  localparam int unsigned KEY_BYTES_DEF     = 15;

  // Hash multiplier and linear probe coefficient.
  localparam int unsigned HASH_MUL  = 19;
  localparam int unsigned PROBE_LIN = 23;

  // Field widths of the input and result items.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KEY_LOW_W  = 64;
  localparam int unsigned KEY_HIGH_W = 56;
  localparam int unsigned KEY_LEN_W  = 4;
  localparam int unsigned KEY_IN_W   = KEY_LOW_W + KEY_HIGH_W;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned COUNT_W    = 7;

  // Field offsets inside tdata, first field in the lowest bits.
  localparam int unsigned FUNC_LSB     = 0;
  localparam int unsigned KEY_LOW_LSB  = FUNC_LSB + FUNC_W;
  localparam int unsigned KEY_HIGH_LSB = KEY_LOW_LSB + KEY_LOW_W;
  localparam int unsigned KEY_LEN_LSB  = KEY_HIGH_LSB + KEY_HIGH_W;
  localparam int unsigned IN_USED_W    = KEY_LEN_LSB + KEY_LEN_W;
  localparam int unsigned IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  localparam int unsigned STATUS_LSB  = 0;
  localparam int unsigned SLOT_LSB    = STATUS_LSB + STATUS_W;
  localparam int unsigned COUNT_LSB   = SLOT_LSB + SLOT_W;
  localparam int unsigned OUT_USED_W  = COUNT_LSB + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Command codes; the fourth code is unused and is dropped without a result.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DEL   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HASH   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_REM    = 7'b0010000,
    S_SEARCH = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// File: sv/quadratic_probe_string_hash_table_unit.sv
// Top level of the quadratic-probe open-addressing hash table for short string keys.
//
// The input channel (in_tvalid, in_tready, in_tdata) carries one command per transfer:
// add a key, delete a key or clear the whole table. The result channel (out_tvalid,
// out_tready, out_tdata) returns one status word per command; the unused command code
// is dropped and gives no result.
// One command is worked on at a time, and in_tready is high only while the block is idle.
// An add or delete raises out_tvalid after these steps in order: the hash accumulator takes
// the key byte by byte, then the hash multiply, then the remainder by the table size
// (reciprocal multiply for the quotient, then multiply back and subtract), then one probe
// per cycle through the key memory read port, and last the read register and the final
// compare drain. The next command is taken only after the result is accepted. An add
// that finds its key stored stops early.
// A clear raises out_tvalid in the cycle after its transfer.
// Reset empties the table and the entry count at once; stored keys are not cleared,
// since a key is only looked at where its slot is marked occupied.
// While the receiver holds out_tready low, the result stays on out_tdata and no new
// command is taken.
`default_nettype none

module quadratic_probe_string_hash_table_unit #(
  parameter int unsigned TABLE_ENTRIES = qpsht_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned PROBE_LIMIT   = qpsht_pkg::PROBE_LIMIT_DEF,
  parameter int unsigned KEY_BYTES     = qpsht_pkg::KEY_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0 up: func, key_low, key_high, key_length, zero fill.
  input  wire logic [qpsht_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // Fields from bit 0 up: status, slot, entry_count, zero fill.
  output logic [qpsht_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import qpsht_pkg::*;

  // Slot index, entry count and probe counter widths.
  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned JW  = $clog2(PROBE_LIMIT + 1);
  // Stored key width and key byte position width.
  localparam int unsigned KW  = KEY_BYTES * 8;
  localparam int unsigned PSW = $clog2(KEY_BYTES + 1);
  // Weighted byte sum and hash product widths.
  localparam int unsigned SUM_MAX = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
  localparam int unsigned SW  = $clog2(SUM_MAX + 1);
  localparam int unsigned PW  = $clog2(SUM_MAX * HASH_MUL + 1);
  // Quotient by reciprocal: (prod * RECIP) >> RSH is exact for every product below 2**PW,
  // since RECIP rounds up by less than the table size.
  localparam int unsigned RSH = PW + AW;
  localparam int unsigned RW  = PW + 2;
  localparam int unsigned QW  = PW + RW - RSH;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  // Step from probe 0 to probe 1 is 1 + PROBE_LIN; each later step grows by two.
  localparam int unsigned D0  = (1 + PROBE_LIN) % TABLE_ENTRIES;

  state_t               state_r;
  func_t                func_r;
  logic [KEY_LEN_W-1:0] len_r;
  logic [KW-1:0]        key_r;
  logic                 alive_r;
  logic [PSW-1:0]       byte_cnt_r;
  logic [SW-1:0]        sum_r;
  logic [PW-1:0]        prod_r;
  logic [QW-1:0]        quot_r;
  logic [AW-1:0]        p_r;
  logic [AW-1:0]        d_r;
  logic [JW-1:0]        j_r;
  logic                 chk_vld_r;
  logic [AW-1:0]        chk_slot_r;
  logic [KW-1:0]        rd_key_r;
  logic                 free_seen_r;
  logic [AW-1:0]        free_slot_r;
  logic                 del_seen_r;
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [CW-1:0]        count_r;
  status_t              out_status_r;
  logic [AW-1:0]        out_slot_r;

  // Key store: one write port for inserts, one registered read port for probing.
  logic [KW-1:0]        key_mem [TABLE_ENTRIES];

  logic [KEY_IN_W-1:0]  in_key;
  logic [7:0]           cur_byte;
  logic [KW-1:0]        byte_mask;
  logic [PSW-1:0]       pos;
  logic                 keep;
  logic [8+PSW-1:0]     byte_prod;
  logic                 hash_last;
  logic [PW+RW-1:0]     recip_prod;
  logic [PW-1:0]        quot_back;
  logic [PW-1:0]        rem_full;
  logic [AW-1:0]        rem_nxt;
  logic [AW:0]          p_sum;
  logic [AW:0]          d_sum;
  logic [AW-1:0]        p_nxt;
  logic [AW-1:0]        d_nxt;
  logic                 issue;
  logic                 chk_used;
  logic                 hit;
  logic                 empty;
  logic                 search_done;
  logic                 mem_we;
  logic                 in_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_key     = in_tdata[KEY_LOW_LSB +: KEY_IN_W];

  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                      COUNT_W'(count_r), SLOT_W'(out_slot_r), out_status_r};

  // Current key byte for the hash accumulator, and a mask over it.
  always_comb begin
    cur_byte  = '0;
    byte_mask = '0;
    for (int k = 0; k < int'(KEY_BYTES); k++) begin
      if (byte_cnt_r == PSW'(k)) begin
        cur_byte            = key_r[k*8 +: 8];
        byte_mask[k*8 +: 8] = 8'hFF;
      end
    end
  end

  // A byte counts while the key has not ended by length or by an earlier zero byte.
  assign pos       = byte_cnt_r + PSW'(1);
  assign keep      = alive_r && ((5)'(byte_cnt_r) < (5)'(len_r)) && (cur_byte != 8'd0);
  assign byte_prod = {{PSW{1'b0}}, cur_byte} * (8 + PSW)'(pos);
  assign hash_last = (byte_cnt_r == PSW'(KEY_BYTES - 1));

  // Remainder by the table size: quotient from the reciprocal, then multiply back.
  assign recip_prod = {{RW{1'b0}}, prod_r} * (PW + RW)'(RECIP);
  assign quot_back  = PW'({{(PW - QW){1'b0}}, quot_r} * PW'(TABLE_ENTRIES));
  assign rem_full   = prod_r - quot_back;
  assign rem_nxt    = rem_full[AW-1:0];

  // Next probe slot and next step, both kept below the table size.
  assign p_sum = {1'b0, p_r} + {1'b0, d_r};
  assign d_sum = {1'b0, d_r} + (AW + 1)'(2);
  always_comb begin
    p_nxt = p_sum[AW-1:0];
    if (p_sum >= (AW + 1)'(TABLE_ENTRIES)) begin
      p_nxt = AW'(p_sum - (AW + 1)'(TABLE_ENTRIES));
    end
    d_nxt = d_sum[AW-1:0];
    if (d_sum >= (AW + 1)'(TABLE_ENTRIES)) begin
      d_nxt = AW'(d_sum - (AW + 1)'(TABLE_ENTRIES));
    end
  end

  // Probe pipeline: a slot is issued to the key memory, then compared in the next cycle.
  // The occupied bit is read at compare time, so a delete sees its own earlier clears.
  assign issue       = (j_r != JW'(PROBE_LIMIT));
  assign chk_used    = used_r[chk_slot_r];
  assign hit         = chk_vld_r && chk_used && (rd_key_r == key_r);
  assign empty       = chk_vld_r && !chk_used;
  assign search_done = !issue && !chk_vld_r;
  assign mem_we      = (state_r == S_SEARCH) && (func_r == FUNC_ADD) &&
                       search_done && free_seen_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[free_slot_r] <= key_r;
    end
    rd_key_r <= key_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      j_r          <= '0;
      alive_r      <= 1'b0;
      free_seen_r  <= 1'b0;
      del_seen_r   <= 1'b0;
      byte_cnt_r   <= '0;
      func_r       <= FUNC_ADD;
      out_status_r <= ST_ADDED;
      out_slot_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            func_r      <= func_t'(in_tdata[FUNC_LSB +: FUNC_W]);
            len_r       <= in_tdata[KEY_LEN_LSB +: KEY_LEN_W];
            key_r       <= in_key[KW-1:0];
            alive_r     <= 1'b1;
            byte_cnt_r  <= '0;
            sum_r       <= '0;
            free_seen_r <= 1'b0;
            del_seen_r  <= 1'b0;
            out_slot_r  <= '0;
            case (in_tdata[FUNC_LSB +: FUNC_W])
              FUNC_ADD, FUNC_DEL: begin
                state_r <= S_HASH;
              end
              FUNC_CLEAR: begin
                used_r       <= '0;
                count_r      <= '0;
                out_status_r <= ST_CLEARED;
                state_r      <= S_RESP;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_HASH: begin
          // Bytes past the end of the key are zeroed so the stored key compares cleanly.
          if (keep) begin
            sum_r <= sum_r + SW'(byte_prod);
          end else begin
            alive_r <= 1'b0;
            key_r   <= key_r & ~byte_mask;
          end
          byte_cnt_r <= pos;
          if (hash_last) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'({{(PW - SW){1'b0}}, sum_r} * PW'(HASH_MUL));
          state_r <= S_MOD;
        end
        S_MOD: begin
          quot_r  <= recip_prod[RSH +: QW];
          state_r <= S_REM;
        end
        S_REM: begin
          p_r       <= rem_nxt;
          d_r       <= AW'(D0);
          j_r       <= '0;
          chk_vld_r <= 1'b0;
          state_r   <= S_SEARCH;
        end
        S_SEARCH: begin
          chk_vld_r <= issue;
          if (issue) begin
            chk_slot_r <= p_r;
            p_r        <= p_nxt;
            d_r        <= d_nxt;
            j_r        <= j_r + JW'(1);
          end
          if (func_r == FUNC_ADD) begin
            if (hit) begin
              out_status_r <= ST_PRESENT;
              out_slot_r   <= chk_slot_r;
              state_r      <= S_RESP;
            end else if (empty && !free_seen_r) begin
              free_seen_r <= 1'b1;
              free_slot_r <= chk_slot_r;
            end
            if (search_done) begin
              if (free_seen_r) begin
                used_r[free_slot_r] <= 1'b1;
                count_r             <= count_r + CW'(1);
                out_status_r        <= ST_ADDED;
                out_slot_r          <= free_slot_r;
              end else begin
                out_status_r <= ST_FULL;
              end
              state_r <= S_RESP;
            end
          end else begin
            if (hit) begin
              used_r[chk_slot_r] <= 1'b0;
              if (count_r != '0) begin
                count_r <= count_r - CW'(1);
              end
              if (!del_seen_r) begin
                out_slot_r <= chk_slot_r;
              end
              del_seen_r <= 1'b1;
            end
            if (search_done) begin
              out_status_r <= del_seen_r ? ST_REMOVED : ST_ABSENT;
              state_r      <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The block never takes a command while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // The entry count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("entry count out of step with occupied slots");

  // Probe slot and step stay inside the table while searching.
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> ((p_r < AW'(TABLE_ENTRIES - 1) || p_r == AW'(TABLE_ENTRIES - 1))
                               && (d_r < AW'(TABLE_ENTRIES - 1) ||
                                   d_r == AW'(TABLE_ENTRIES - 1))))
    else $error("probe slot beyond the table");

  // A clear command empties the table and answers in the next cycle.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tdata[FUNC_LSB +: FUNC_W] == FUNC_CLEAR)) |=>
      (out_tvalid && (count_r == '0) && (used_r == '0)))
    else $error("clear did not empty the table");

endmodule

`default_nettype wire
